// File: design/font_glyph_blitter_macros.svh
// ----------------------------------------------------------------------------
// Font glyph blitter assertion macros
// Concurrent check wrappers; they expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef FONT_GLYPH_BLITTER_MACROS_SVH
`define FONT_GLYPH_BLITTER_MACROS_SVH
`ifndef SYNTHESIS
// Check with reset disable.
`define FGB_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: check failed");
// Check that also holds during reset.
`define FGB_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) else $error("%m: check failed");
`else
`define FGB_ASSERT(lbl, clk, rst_n, prop)
`define FGB_ASSERT_NR(lbl, clk, prop)
`endif
`endif

// File: design/fgb_pkg.sv
// ----------------------------------------------------------------------------
// Font glyph blitter package
// Widths, codes and the command/status words shared by the blitter modules.
// ----------------------------------------------------------------------------
`default_nettype none

package fgb_pkg;

  localparam int unsigned SIDE_W     = 4;
  localparam int unsigned COORD_W    = 8;
  localparam int unsigned PEN_W      = 11;
  localparam int unsigned PIX_W      = 8;
  localparam int unsigned FB_W       = 16;
  localparam int unsigned AIDX_W     = 16;
  localparam int unsigned AW_W       = 9;
  localparam int unsigned ATL_ADDR_W = 18;
  localparam int unsigned CODE_W     = 8;

  localparam logic [AW_W-1:0] AW_RESET = 9'd256;
  localparam int              PEN_MAX  = 1023;

  typedef enum logic [1:0] {
    FN_LOAD  = 2'd0,
    FN_ATLAS = 2'd1,
    FN_PEN   = 2'd2,
    FN_DRAW  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FETCH,
    ST_WALK
  } state_e;

  typedef struct packed {
    logic [COORD_W-1:0] gx;
    logic [COORD_W-1:0] gy;
    logic [SIDE_W-1:0]  gw;
    logic [SIDE_W-1:0]  gh;
  } glyph_t;

  typedef struct packed {
    func_e                     func;
    logic                      font_index;
    logic [CODE_W-1:0]         glyph_code;
    logic [COORD_W-1:0]        glyph_atlas_x;
    logic [COORD_W-1:0]        glyph_atlas_y;
    logic [SIDE_W-1:0]         glyph_width;
    logic [SIDE_W-1:0]         glyph_height;
    logic [AIDX_W-1:0]         atlas_index;
    logic [PIX_W-1:0]          atlas_pixel;
    logic signed [PEN_W-1:0]   pen_x;
    logic signed [PEN_W-1:0]   pen_y;
  } in_word_t;

  typedef struct packed {
    logic [FB_W-1:0]  fb_index;
    logic [PIX_W-1:0] color;
    logic             last;
  } out_word_t;

  typedef struct packed {
    logic clear;
    logic tbl_write;
    logic atlas_write;
    logic pen_set;
    logic tbl_read;
    logic start;
    logic walk;
    logic finish;
  } cmd_t;

  typedef struct packed {
    func_e func;
    logic  slot_ok;
    logic  draw_ok;
    logic  atlas_ok;
    logic  clr_last;
    logic  fin_ok;
  } status_t;

endpackage

`default_nettype wire

// File: design/fgb_intf.sv
// ----------------------------------------------------------------------------
// Font glyph blitter channels
// Valid/ready channels for input words, result words and configuration.
// ----------------------------------------------------------------------------
`default_nettype none

interface fgb_in_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          func;
  logic                                font_index;
  logic [fgb_pkg::CODE_W-1:0]          glyph_code;
  logic [fgb_pkg::COORD_W-1:0]         glyph_atlas_x;
  logic [fgb_pkg::COORD_W-1:0]         glyph_atlas_y;
  logic [fgb_pkg::SIDE_W-1:0]          glyph_width;
  logic [fgb_pkg::SIDE_W-1:0]          glyph_height;
  logic [fgb_pkg::AIDX_W-1:0]          atlas_index;
  logic [fgb_pkg::PIX_W-1:0]           atlas_pixel;
  logic signed [fgb_pkg::PEN_W-1:0]    pen_x;
  logic signed [fgb_pkg::PEN_W-1:0]    pen_y;

  modport source (
    output valid, func, font_index, glyph_code, glyph_atlas_x, glyph_atlas_y,
           glyph_width, glyph_height, atlas_index, atlas_pixel, pen_x, pen_y,
    input  ready
  );
  modport sink (
    input  valid, func, font_index, glyph_code, glyph_atlas_x, glyph_atlas_y,
           glyph_width, glyph_height, atlas_index, atlas_pixel, pen_x, pen_y,
    output ready
  );
endinterface

interface fgb_out_if;
  logic                         valid;
  logic                         ready;
  logic [fgb_pkg::FB_W-1:0]     fb_index;
  logic [fgb_pkg::PIX_W-1:0]    color;
  logic                         last;

  modport source (output valid, fb_index, color, last, input ready);
  modport sink (input valid, fb_index, color, last, output ready);
endinterface

interface fgb_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [fgb_pkg::AW_W-1:0]    data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

// File: design/fgb_ctrl.sv
// ----------------------------------------------------------------------------
// Font glyph blitter controller
// Sequences table clear, item dispatch, glyph fetch and the pixel walk.
// ----------------------------------------------------------------------------
`default_nettype none

module fgb_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  fgb_pkg::status_t status_i,
  output fgb_pkg::cmd_t    cmd_o
);

  fgb_pkg::state_e state_q, state_d;
  logic            accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fgb_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign accept = in_valid_i && in_ready_o;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fgb_pkg::ST_CLEAR: begin
        if (status_i.clr_last) state_d = fgb_pkg::ST_IDLE;
      end
      fgb_pkg::ST_IDLE: begin
        if (accept && status_i.func == fgb_pkg::FN_DRAW && status_i.draw_ok) begin
          state_d = fgb_pkg::ST_FETCH;
        end
      end
      fgb_pkg::ST_FETCH: begin
        state_d = fgb_pkg::ST_WALK;
      end
      fgb_pkg::ST_WALK: begin
        if (status_i.fin_ok) state_d = fgb_pkg::ST_IDLE;
      end
      default: state_d = fgb_pkg::ST_CLEAR;
    endcase
  end

  // Outputs.
  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      fgb_pkg::ST_CLEAR: begin
        cmd_o.clear = 1'b1;
      end
      fgb_pkg::ST_IDLE: begin
        in_ready_o        = 1'b1;
        cmd_o.tbl_write   = in_valid_i && status_i.func == fgb_pkg::FN_LOAD
                            && status_i.slot_ok;
        cmd_o.atlas_write = in_valid_i && status_i.func == fgb_pkg::FN_ATLAS
                            && status_i.atlas_ok;
        cmd_o.pen_set     = in_valid_i && status_i.func == fgb_pkg::FN_PEN;
        cmd_o.tbl_read    = in_valid_i && status_i.func == fgb_pkg::FN_DRAW
                            && status_i.draw_ok;
      end
      fgb_pkg::ST_FETCH: begin
        cmd_o.start = 1'b1;
      end
      fgb_pkg::ST_WALK: begin
        cmd_o.walk   = 1'b1;
        cmd_o.finish = status_i.fin_ok;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: design/fgb_datapath.sv
// ----------------------------------------------------------------------------
// Font glyph blitter datapath
// Glyph table, atlas memory, pen, pixel walker and the result pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module fgb_datapath #(
  parameter int SCREEN_WIDTH   = 320,
  parameter int SCREEN_HEIGHT  = 200,
  parameter int MAX_GLYPH_SIDE = 8,
  parameter int ATLAS_WORDS    = 65536,
  parameter int GLYPH_CODES    = 256,
  parameter int FONT_COUNT     = 2
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  fgb_pkg::in_word_t              in_word_i,
  input  logic                           cfg_we_i,
  input  logic [fgb_pkg::AW_W-1:0]       cfg_data_i,
  input  fgb_pkg::cmd_t                  cmd_i,
  output fgb_pkg::status_t               status_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output fgb_pkg::out_word_t             out_word_o
);

  localparam int TBL_DEPTH = FONT_COUNT * GLYPH_CODES;
  localparam int TBL_AW    = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;
  localparam int ATL_AW    = $clog2(ATLAS_WORDS);
  localparam int SUM_W     = fgb_pkg::PEN_W + 1;

  localparam logic signed [SUM_W-1:0] SH_S   = SUM_W'(SCREEN_HEIGHT);
  localparam logic signed [SUM_W-1:0] SW_S   = SUM_W'(SCREEN_WIDTH);
  localparam logic signed [SUM_W-1:0] PMAX_S = SUM_W'(fgb_pkg::PEN_MAX);
  localparam logic [fgb_pkg::SIDE_W-1:0] MAXS = fgb_pkg::SIDE_W'(MAX_GLYPH_SIDE);

  // --- item decode ---------------------------------------------------------
  logic              slot_ok;
  logic              atlas_ok;
  logic [TBL_AW-1:0] slot;
  logic              adv;
  logic              fin_ok;

  assign slot_ok  = (32'(in_word_i.font_index) < FONT_COUNT)
                 && (32'(in_word_i.glyph_code) < GLYPH_CODES);
  assign atlas_ok = 32'(in_word_i.atlas_index) < ATLAS_WORDS;
  assign slot     = TBL_AW'(in_word_i.font_index) * TBL_AW'(GLYPH_CODES)
                  + TBL_AW'(in_word_i.glyph_code);

  // --- configuration -------------------------------------------------------
  logic [fgb_pkg::AW_W-1:0] aw_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      aw_q <= fgb_pkg::AW_RESET;
    end else if (cfg_we_i) begin
      aw_q <= cfg_data_i;
    end
  end

  // --- glyph table with clear sweep ----------------------------------------
  fgb_pkg::glyph_t   tbl_mem [TBL_DEPTH];
  fgb_pkg::glyph_t   tbl_rd_q;
  fgb_pkg::glyph_t   tbl_wr;
  logic [TBL_AW-1:0] clr_cnt_q;

  always_comb begin
    tbl_wr.gx = in_word_i.glyph_atlas_x;
    tbl_wr.gy = in_word_i.glyph_atlas_y;
    tbl_wr.gw = (in_word_i.glyph_width > MAXS) ? MAXS : in_word_i.glyph_width;
    tbl_wr.gh = (in_word_i.glyph_height > MAXS) ? MAXS : in_word_i.glyph_height;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clear) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      tbl_mem[clr_cnt_q] <= '0;
    end else if (cmd_i.tbl_write) begin
      tbl_mem[slot] <= tbl_wr;
    end
    if (cmd_i.tbl_read) begin
      tbl_rd_q <= tbl_mem[slot];
    end
  end

  // --- pen -----------------------------------------------------------------
  logic signed [fgb_pkg::PEN_W-1:0] pen_col_q;
  logic signed [fgb_pkg::PEN_W-1:0] pen_row_q;
  logic signed [SUM_W-1:0]          pen_sum;
  logic [fgb_pkg::SIDE_W-1:0]       gw_q;

  assign pen_sum = {pen_col_q[fgb_pkg::PEN_W-1], pen_col_q} + SUM_W'(gw_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pen_col_q <= '0;
      pen_row_q <= '0;
    end else if (cmd_i.pen_set) begin
      pen_col_q <= in_word_i.pen_x;
      pen_row_q <= in_word_i.pen_y;
    end else if (cmd_i.finish) begin
      // saturate the advanced column
      pen_col_q <= (pen_sum > PMAX_S) ? fgb_pkg::PEN_W'(fgb_pkg::PEN_MAX)
                                      : pen_sum[fgb_pkg::PEN_W-1:0];
    end
  end

  // --- pixel walker --------------------------------------------------------
  logic [fgb_pkg::COORD_W-1:0] gx_q, gy_q;
  logic [fgb_pkg::SIDE_W-1:0]  gh_q;
  logic [fgb_pkg::SIDE_W-1:0]  x_q, x_d, y_q, y_d;
  logic                        walk_q, walk_d;
  logic                        emit;
  logic signed [SUM_W-1:0]     row_s, col_s;
  logic [fgb_pkg::SIDE_W:0]    x_inc;

  assign adv   = !out_valid_o || out_ready_i;
  assign row_s = {pen_row_q[fgb_pkg::PEN_W-1], pen_row_q} + SUM_W'(y_q);
  assign col_s = {pen_col_q[fgb_pkg::PEN_W-1], pen_col_q} + SUM_W'(x_q);
  assign x_inc = {1'b0, x_q} + 1'b1;

  // One glyph position per step; skip rows above the screen, end the walk
  // below it, end a row at the right edge.
  always_comb begin
    walk_d = walk_q;
    x_d    = x_q;
    y_d    = y_q;
    emit   = 1'b0;
    if (cmd_i.walk && walk_q && adv) begin
      priority if (y_q >= gh_q) begin
        walk_d = 1'b0;
      end else if (row_s < 0) begin
        y_d = y_q + 1'b1;
        x_d = '0;
      end else if (row_s >= SH_S) begin
        walk_d = 1'b0;
      end else if (x_q >= gw_q || col_s >= SW_S) begin
        y_d = y_q + 1'b1;
        x_d = '0;
      end else begin
        emit = !col_s[SUM_W-1];
        if (x_inc >= {1'b0, gw_q}) begin
          y_d = y_q + 1'b1;
          x_d = '0;
        end else begin
          x_d = x_inc[fgb_pkg::SIDE_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walk_q <= 1'b0;
    end else if (cmd_i.start) begin
      walk_q <= 1'b1;
    end else begin
      walk_q <= walk_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      gx_q <= tbl_rd_q.gx;
      gy_q <= tbl_rd_q.gy;
      gw_q <= tbl_rd_q.gw;
      gh_q <= tbl_rd_q.gh;
      x_q  <= '0;
      y_q  <= '0;
    end else begin
      x_q <= x_d;
      y_q <= y_d;
    end
  end

  // --- stage 1: atlas and framebuffer addresses ----------------------------
  logic                              s1_v_q;
  logic [fgb_pkg::ATL_ADDR_W-1:0]    s1_a_q, atl_a;
  logic [fgb_pkg::FB_W-1:0]          s1_fb_q, fb_a;

  assign atl_a = fgb_pkg::ATL_ADDR_W'({1'b0, gx_q} + 9'(x_q))
               + fgb_pkg::ATL_ADDR_W'({1'b0, gy_q} + 9'(y_q))
               * fgb_pkg::ATL_ADDR_W'(aw_q);
  assign fb_a  = fgb_pkg::FB_W'(col_s[9:0])
               + fgb_pkg::FB_W'(row_s[9:0]) * fgb_pkg::FB_W'(SCREEN_WIDTH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (adv) begin
      s1_v_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_a_q  <= atl_a;
      s1_fb_q <= fb_a;
    end
  end

  // --- stage 2: atlas read -------------------------------------------------
  logic [fgb_pkg::PIX_W-1:0] atl_mem [ATLAS_WORDS];
  logic [fgb_pkg::PIX_W-1:0] pix_q;
  logic                      s2_v_q;
  logic [fgb_pkg::FB_W-1:0]  s2_fb_q;
  logic                      opaque;

  always_ff @(posedge clk_i) begin
    if (cmd_i.atlas_write) begin
      atl_mem[in_word_i.atlas_index[ATL_AW-1:0]] <= in_word_i.atlas_pixel;
    end
    if (adv) begin
      pix_q   <= atl_mem[s1_a_q[ATL_AW-1:0]];
      s2_fb_q <= s1_fb_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (adv) begin
      // out-of-range atlas reads count as transparent
      s2_v_q <= s1_v_q && (s1_a_q < fgb_pkg::ATL_ADDR_W'(ATLAS_WORDS));
    end
  end

  assign opaque = s2_v_q && (pix_q != '0);

  // --- pending pixel and output register -----------------------------------
  // Hold one opaque pixel back so the final one can carry the last flag.
  logic                      pend_v_q;
  logic [fgb_pkg::FB_W-1:0]  pend_fb_q;
  logic [fgb_pkg::PIX_W-1:0] pend_col_q;
  logic                      load_mid, load_end;
  logic                      out_v_q, out_v_d;
  fgb_pkg::out_word_t        out_q;

  assign fin_ok   = !walk_q && !s1_v_q && !s2_v_q && adv;
  assign load_mid = adv && opaque && pend_v_q;
  assign load_end = cmd_i.finish && pend_v_q;

  always_comb begin
    out_v_d = out_v_q;
    if (load_mid || load_end) begin
      out_v_d = 1'b1;
    end else if (out_ready_i) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      out_v_q <= out_v_d;
      if (adv && opaque) begin
        pend_v_q <= 1'b1;
      end else if (cmd_i.finish) begin
        pend_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && opaque) begin
      pend_fb_q  <= s2_fb_q;
      pend_col_q <= pix_q;
    end
    if (load_mid || load_end) begin
      out_q.fb_index <= pend_fb_q;
      out_q.color    <= pend_col_q;
      out_q.last     <= load_end;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_word_o  = out_q;

  // --- status --------------------------------------------------------------
  always_comb begin
    status_o.func     = in_word_i.func;
    status_o.slot_ok  = slot_ok;
    status_o.draw_ok  = slot_ok && (in_word_i.glyph_code != '0);
    status_o.atlas_ok = atlas_ok;
    status_o.clr_last = clr_cnt_q == TBL_AW'(TBL_DEPTH - 1);
    status_o.fin_ok   = fin_ok;
  end

endmodule

`default_nettype wire

// File: design/font_glyph_blitter.sv
// ----------------------------------------------------------------------------
// Font glyph blitter
// Draws characters from a glyph table and an atlas into framebuffer writes.
// ----------------------------------------------------------------------------
// Each input word loads a glyph table entry, writes one atlas pixel, sets the
// pen, or draws one character at the pen. A draw reads the table entry, loads
// the walker, visits glyph positions, at most height times max(width, 1)
// positions, then drains the address, atlas-read and hold stages; the walker
// steps one position per cycle and stalls while the output register is full
// and not taken. Each opaque pixel gives one result word (framebuffer index,
// color) and the last word of a character carries last. Rows above and
// columns left of the screen are skipped, the bottom edge ends the walk and
// the right edge ends the row; the pen column then advances by the glyph
// width, saturating at 1023. After reset the block clears all FONT_COUNT *
// GLYPH_CODES glyph table entries (512 by default), one entry per cycle, and
// takes no input words until that is done.
// Atlas contents are undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none
`include "font_glyph_blitter_macros.svh"

module font_glyph_blitter #(
  parameter int SCREEN_WIDTH   = 320,
  parameter int SCREEN_HEIGHT  = 200,
  parameter int MAX_GLYPH_SIDE = 8,
  parameter int ATLAS_WORDS    = 65536,
  parameter int GLYPH_CODES    = 256,
  parameter int FONT_COUNT     = 2
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  fgb_in_if.sink    in_i,
  fgb_out_if.source out_o,
  fgb_cfg_if.sink   cfg_i
);

  fgb_pkg::in_word_t  in_word;
  fgb_pkg::out_word_t out_word;
  fgb_pkg::cmd_t      cmd;
  fgb_pkg::status_t   status;
  logic               in_ready;
  logic               out_valid;

  // Pack the input word for the datapath.
  always_comb begin
    in_word.func          = fgb_pkg::func_e'(in_i.func);
    in_word.font_index    = in_i.font_index;
    in_word.glyph_code    = in_i.glyph_code;
    in_word.glyph_atlas_x = in_i.glyph_atlas_x;
    in_word.glyph_atlas_y = in_i.glyph_atlas_y;
    in_word.glyph_width   = in_i.glyph_width;
    in_word.glyph_height  = in_i.glyph_height;
    in_word.atlas_index   = in_i.atlas_index;
    in_word.atlas_pixel   = in_i.atlas_pixel;
    in_word.pen_x         = in_i.pen_x;
    in_word.pen_y         = in_i.pen_y;
  end

  assign in_i.ready = in_ready;

  // The atlas width register takes a write in any cycle.
  assign cfg_i.ready = 1'b1;

  fgb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  fgb_datapath #(
    .SCREEN_WIDTH   (SCREEN_WIDTH),
    .SCREEN_HEIGHT  (SCREEN_HEIGHT),
    .MAX_GLYPH_SIDE (MAX_GLYPH_SIDE),
    .ATLAS_WORDS    (ATLAS_WORDS),
    .GLYPH_CODES    (GLYPH_CODES),
    .FONT_COUNT     (FONT_COUNT)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word_i   (in_word),
    .cfg_we_i    (cfg_i.valid),
    .cfg_data_i  (cfg_i.data),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .out_word_o  (out_word)
  );

  // Drive the result channel from the output register.
  assign out_o.valid    = out_valid;
  assign out_o.fb_index = out_word.fb_index;
  assign out_o.color    = out_word.color;
  assign out_o.last     = out_word.last;

  // --- checks --------------------------------------------------------------
  // At most one memory or sequencing command per cycle.
  `FGB_ASSERT(a_cmd_onehot, clk_i, rst_ni, $onehot0({cmd.clear, cmd.tbl_write, cmd.atlas_write, cmd.pen_set, cmd.tbl_read, cmd.start, cmd.finish}))
  // No word is taken while the table clear sweep runs.
  `FGB_ASSERT(a_clear_blocks_input, clk_i, rst_ni, cmd.clear |-> !in_i.ready)
  // A walker load is always followed by the walk.
  `FGB_ASSERT(a_start_then_walk, clk_i, rst_ni, cmd.start |=> cmd.walk)
  // Transparent pixels never reach the result channel.
  `FGB_ASSERT_NR(a_color_opaque, clk_i, out_o.valid |-> (out_o.color != 8'd0))

endmodule

`default_nettype wire
